/* src/ecal_pkg.sv */
// ----------------------------------------------------------------------------
// ecal_pkg: shared types and constants for the epoch to calendar converter
// Constants of the calendar arithmetic, cumulative month table and the
// structs that travel between the sequencer, the subtract unit and the top.
// ----------------------------------------------------------------------------
package ecal_pkg;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_NORM     = 365;
    localparam int unsigned DAYS_LEAP     = 366;
    localparam int unsigned DAYS_QUAD     = 1461;

    // quotient widths of the three restoring divisions
    localparam int unsigned DAY_QBITS  = 16;
    localparam int unsigned HOUR_QBITS = 5;
    localparam int unsigned MIN_QBITS  = 6;

    localparam logic [31:0] DVS_DAY  = 32'(SECS_PER_DAY)  << (DAY_QBITS - 1);
    localparam logic [31:0] DVS_HOUR = 32'(SECS_PER_HOUR) << (HOUR_QBITS - 1);
    localparam logic [31:0] DVS_MIN  = 32'(SECS_PER_MIN)  << (MIN_QBITS - 1);

    // years counted from 1900
    localparam logic [7:0] YEAR_EPOCH   = 8'd70;
    localparam logic [7:0] YEAR_QUAD_CY = 8'd198;  // four-year block holding 2100
    localparam logic [7:0] YEAR_CENTURY = 8'd200;  // 2100, not a leap year

    localparam logic [2:0] EPOCH_WDAY = 3'd4;      // 1970-01-01 was a Thursday
    localparam logic [3:0] MONTH_DEC  = 4'd11;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic        ge;
        logic [31:0] diff;
    } t_cmp_res;

    typedef struct packed {
        logic [5:0] sec_of_minute;
        logic [5:0] min_of_hour;
        logic [4:0] hour_of_day;
        logic [2:0] week_day;
        logic [7:0] years_since_1900;
        logic [3:0] month_index;
        logic [4:0] month_day;
        logic [8:0] year_day;
    } t_result;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_status;

    // days before the first of a month
    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        if (leap && (mon >= 4'd2)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    // valid for 1970..2155, the only non-leap century year in range being 2100
    function automatic logic is_leap(input logic [7:0] yr);
        return (yr[1:0] == 2'b00) && (yr != YEAR_CENTURY);
    endfunction

endpackage

/* src/ecal_cmp_sub.sv */
// ----------------------------------------------------------------------------
// ecal_cmp_sub: shared compare and subtract unit
// Gives a - b and whether a >= b; used by every step of the sequencer.
// ----------------------------------------------------------------------------
module ecal_cmp_sub
    import ecal_pkg::*;
(
    input  t_cmp_req i_req,
    output t_cmp_res o_res
);

    logic [32:0] w_diff;

    assign w_diff     = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_res.ge   = ~w_diff[32];
    assign o_res.diff = w_diff[31:0];

endmodule

/* src/ecal_seq.sv */
// ----------------------------------------------------------------------------
// ecal_seq: conversion sequencer
// Drives the shared subtract unit through day, hour and minute division,
// the year search and the month search, and holds the finished result.
// ----------------------------------------------------------------------------
module ecal_seq
    import ecal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_epoch_seconds,
    input  logic        i_take,
    input  t_cmp_res    i_cmp,
    output t_cmp_req    o_cmp,
    output t_seq_status o_status,
    output t_result     o_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_DIV_HOUR,
        ST_DIV_MIN,
        ST_YEAR4,
        ST_YEAR1,
        ST_MONTH,
        ST_HOLD
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_dvs, n_dvs;
    logic [15:0] r_days, n_days;
    logic [2:0]  r_w, n_w;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [2:0]  r_wday, n_wday;
    logic [7:0]  r_year, n_year;
    logic [8:0]  r_yday, n_yday;
    logic        r_leap, n_leap;
    logic [3:0]  r_mon, n_mon;
    logic [4:0]  r_mday, n_mday;

    logic [3:0]  w_w2;
    logic [2:0]  w_wmod;
    logic [3:0]  w_wofs;

    // operand select for the shared unit
    always_comb begin
        o_cmp.a = r_acc;
        case (r_state)
            ST_YEAR4: o_cmp.b = (r_year == YEAR_QUAD_CY) ? 32'(DAYS_QUAD - 1)
                                                          : 32'(DAYS_QUAD);
            ST_YEAR1: o_cmp.b = is_leap(r_year) ? 32'(DAYS_LEAP) : 32'(DAYS_NORM);
            ST_MONTH: o_cmp.b = {23'b0, cum_days(r_leap, r_mon)};
            default:  o_cmp.b = r_dvs;
        endcase
    end

    // running days mod 7 as quotient bits arrive msb first
    assign w_w2   = {r_w, i_cmp.ge};
    assign w_wmod = (w_w2 >= 4'd7) ? 3'(w_w2 - 4'd7) : w_w2[2:0];
    assign w_wofs = {1'b0, w_wmod} + {1'b0, EPOCH_WDAY};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_dvs   = r_dvs;
        n_days  = r_days;
        n_w     = r_w;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_wday  = r_wday;
        n_year  = r_year;
        n_yday  = r_yday;
        n_leap  = r_leap;
        n_mon   = r_mon;
        n_mday  = r_mday;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_acc   = i_epoch_seconds;
                    n_dvs   = DVS_DAY;
                    n_cnt   = 4'(DAY_QBITS - 1);
                    n_w     = 3'd0;
                    n_state = ST_DIV_DAY;
                end
            end
            ST_DIV_DAY: begin
                if (i_cmp.ge) begin
                    n_acc = i_cmp.diff;
                end
                n_days = {r_days[14:0], i_cmp.ge};
                n_w    = w_wmod;
                n_dvs  = r_dvs >> 1;
                n_cnt  = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_wday  = (w_wofs >= 4'd7) ? 3'(w_wofs - 4'd7) : w_wofs[2:0];
                    n_dvs   = DVS_HOUR;
                    n_cnt   = 4'(HOUR_QBITS - 1);
                    n_state = ST_DIV_HOUR;
                end
            end
            ST_DIV_HOUR: begin
                if (i_cmp.ge) begin
                    n_acc = i_cmp.diff;
                end
                n_hour = {r_hour[3:0], i_cmp.ge};
                n_dvs  = r_dvs >> 1;
                n_cnt  = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_dvs   = DVS_MIN;
                    n_cnt   = 4'(MIN_QBITS - 1);
                    n_state = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN: begin
                if (i_cmp.ge) begin
                    n_acc = i_cmp.diff;
                end
                n_min = {r_min[4:0], i_cmp.ge};
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    // remainder is the second, day count moves into the accumulator
                    n_sec   = n_acc[5:0];
                    n_acc   = {16'b0, r_days};
                    n_year  = YEAR_EPOCH;
                    n_state = ST_YEAR4;
                end
            end
            ST_YEAR4: begin
                if (i_cmp.ge) begin
                    n_acc  = i_cmp.diff;
                    n_year = r_year + 8'd4;
                end else begin
                    n_state = ST_YEAR1;
                end
            end
            ST_YEAR1: begin
                if (i_cmp.ge) begin
                    n_acc  = i_cmp.diff;
                    n_year = r_year + 8'd1;
                end else begin
                    n_yday  = r_acc[8:0];
                    n_leap  = is_leap(r_year);
                    n_mon   = MONTH_DEC;
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                // january starts at zero, so the search ends there at the latest
                if (i_cmp.ge) begin
                    n_mday  = i_cmp.diff[4:0] + 5'd1;
                    n_state = ST_HOLD;
                end else begin
                    n_mon = r_mon - 4'd1;
                end
            end
            ST_HOLD: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_dvs  <= n_dvs;
        r_days <= n_days;
        r_w    <= n_w;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_wday <= n_wday;
        r_year <= n_year;
        r_yday <= n_yday;
        r_leap <= n_leap;
        r_mon  <= n_mon;
        r_mday <= n_mday;
    end

    assign o_status.idle      = (r_state == ST_IDLE);
    assign o_status.res_valid = (r_state == ST_HOLD);

    assign o_result.sec_of_minute    = r_sec;
    assign o_result.min_of_hour      = r_min;
    assign o_result.hour_of_day      = r_hour;
    assign o_result.week_day         = r_wday;
    assign o_result.years_since_1900 = r_year;
    assign o_result.month_index      = r_mon;
    assign o_result.month_day        = r_mday;
    assign o_result.year_day         = r_yday;

endmodule

/* src/epoch_seconds_to_calendar_unit.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: seconds since 1970 to calendar fields
// Converts an unsigned 32-bit epoch second count into second, minute, hour,
// weekday, year, month, day of month and day of year.
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+---------------------------------
//  input    | i_in_valid   | o_in_ready   | i_epoch_seconds
//  output   | o_out_valid  | i_out_ready  | o_sec_of_minute .. o_year_day
//
// one transaction runs from the accepting edge to the edge that loads the
// output register through restoring division of days, hours and minutes,
// 1 to 35 four-year steps, 1 to 4 single-year steps, 1 to 12 month steps
// and the load from the hold state, all on one shared subtractor.
// o_in_ready is high only while the sequencer is idle; a finished result
// waits in the sequencer until the output register is free.
// synchronous active-low reset clears sequencer state and output valid.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit
    import ecal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_sec_of_minute,
    output logic [5:0]  o_min_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [2:0]  o_week_day,
    output logic [7:0]  o_years_since_1900,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_month_day,
    output logic [8:0]  o_year_day
);

    t_cmp_req    w_req;
    t_cmp_res    w_res;
    t_seq_status w_status;
    t_result     w_result;
    logic        w_start;
    logic        w_load;
    logic        r_out_valid;
    t_result     r_out;

    assign w_start = i_in_valid && w_status.idle;
    assign w_load  = w_status.res_valid && (!r_out_valid || i_out_ready);

    ecal_cmp_sub u_cmp (
        .i_req (w_req),
        .o_res (w_res)
    );

    ecal_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_start),
        .i_epoch_seconds (i_epoch_seconds),
        .i_take          (w_load),
        .i_cmp           (w_res),
        .o_cmp           (w_req),
        .o_status        (w_status),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_in_ready         = w_status.idle;
    assign o_out_valid        = r_out_valid;
    assign o_sec_of_minute    = r_out.sec_of_minute;
    assign o_min_of_hour      = r_out.min_of_hour;
    assign o_hour_of_day      = r_out.hour_of_day;
    assign o_week_day         = r_out.week_day;
    assign o_years_since_1900 = r_out.years_since_1900;
    assign o_month_index      = r_out.month_index;
    assign o_month_day        = r_out.month_day;
    assign o_year_day         = r_out.year_day;

endmodule

/* src/ecal_checker.sv */
// ----------------------------------------------------------------------------
// ecal_checker: port-level checks for the epoch to calendar converter
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module ecal_checker
    import ecal_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_epoch_seconds,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_sec_of_minute,
    input logic [5:0]  o_min_of_hour,
    input logic [4:0]  o_hour_of_day,
    input logic [2:0]  o_week_day,
    input logic [7:0]  o_years_since_1900,
    input logic [3:0]  o_month_index,
    input logic [4:0]  o_month_day,
    input logic [8:0]  o_year_day
);

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("state after reset not idle");

    // one transaction at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a conversion is running");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_year_day)
            && $stable(o_years_since_1900) && $stable(o_month_day))
        else $error("stalled result dropped or changed");

    a_field_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sec_of_minute < 6'd60) && (o_min_of_hour < 6'd60)
            && (o_hour_of_day < 5'd24) && (o_week_day < 3'd7)
            && (o_month_index < 4'd12) && (o_month_day != 5'd0)
            && (o_year_day < 9'd366 || o_year_day == 9'd365))
        else $error("calendar field out of range");

    // day 365 only exists as the last day of a leap year
    a_last_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_year_day == 9'd365) |->
            (o_month_index == 4'd11) && (o_month_day == 5'd31)
            && (o_years_since_1900[1:0] == 2'b00))
        else $error("last day of year inconsistent");

endmodule

bind epoch_seconds_to_calendar_unit ecal_checker u_ecal_checker (.*);
